// File: src/bfep_pkg.sv
// ============================================================================
// bfep_pkg
// Shared types and constants of the beacon frame element parser.
// ============================================================================
package bfep_pkg;

    // Result kinds carried on the output tuser.
    localparam logic [1:0] KIND_BSSID   = 2'd0;
    localparam logic [1:0] KIND_SSID    = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    // Frame recognition.
    localparam logic [1:0] PTYPE_MGMT   = 2'd0;
    localparam logic [7:0] FC_BEACON    = 8'h80;

    // Frame layout.
    localparam int BSSID_FIRST = 16;
    localparam int BSSID_LAST  = 21;
    localparam int IE_START    = 36;
    localparam int FCS_BYTES   = 4;

    // Element identifiers.
    localparam logic [7:0] EID_SSID = 8'd0;
    localparam logic [7:0] EID_RSN  = 8'd48;

    // RSN suite selector: OUI bytes and AKM suite types.
    localparam logic [7:0] OUI_B0        = 8'h00;
    localparam logic [7:0] OUI_B1        = 8'h0F;
    localparam logic [7:0] OUI_B2        = 8'hAC;
    localparam logic [7:0] AKM_PSK       = 8'h02;
    localparam logic [7:0] AKM_FT_PSK    = 8'h04;
    localparam logic [7:0] AKM_SAE_LEG   = 8'h08;
    localparam logic [7:0] AKM_SAE       = 8'h0C;

    // Output queue geometry.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    // One result item.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] security;
        logic       last;
    } result_t;

    // Results produced by one input byte, handed to the output queue.
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

// File: src/bfep_parse_core.sv
// ============================================================================
// bfep_parse_core
// Input register and frame walker: turns one frame byte into up to two results.
// ============================================================================
module bfep_parse_core
    import bfep_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_data,
    input  logic        in_sof,
    input  logic [1:0]  in_ptype,
    input  logic [11:0] in_len,
    input  logic        queue_room,
    output push_t       push
);

    localparam int PW = $clog2(MAX_FRAME_BYTES);
    localparam int LW = PW + 1;
    localparam int NW = PW + 9;
    localparam int CW = (PW > 12) ? PW : 12;
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_FRAME_BYTES - 1);

    typedef enum logic [1:0] {PH_IDLE, PH_LEN, PH_BODY, PH_STOP} phase_t;

    // Input register.
    logic        iv_reg;
    logic [7:0]  data_reg;
    logic        sof_reg;
    logic [1:0]  ptype_reg;
    logic [11:0] len_reg;

    // Walker state.
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] slen_reg, slen_next;
    logic          beacon_reg, beacon_next;
    phase_t        phase_reg, phase_next;
    logic [NW-1:0] npos_reg, npos_next;
    logic [7:0]    eid_reg, eid_next;
    logic [7:0]    elen_reg, elen_next;
    logic [7:0]    off_reg, off_next;
    logic [15:0]   pw_reg, pw_next;
    logic [15:0]   akm_reg, akm_next;
    logic [15:0]   idx_reg, idx_next;
    logic [1:0]    oui_reg, oui_next;
    logic          w2_reg, w2_next;
    logic          w3_reg, w3_next;

    logic          advance;
    logic [PW-1:0] cur_pos, cur_slen;
    logic          cur_beacon;
    phase_t        cur_phase;
    logic [NW-1:0] cur_npos;
    logic [7:0]    cur_eid, cur_elen, cur_off;
    logic [15:0]   cur_pw, cur_akm, cur_idx;
    logic [1:0]    cur_oui;
    logic          cur_w2, cur_w3;
    logic [CW-1:0] len_wide;
    logic [LW-1:0] p_ext, l_ext;
    logic [18:0]   akm_at, o_wide;
    logic [7:0]    new_off;
    logic          e_bssid, e_ssid, e_verd, e_done;
    logic [1:0]    verdict;
    logic [1:0]    n;
    result_t       ev, r0, r1;

    // A byte moves on when the queue can take two results.
    assign advance  = iv_reg && queue_room;
    assign in_ready = !iv_reg || queue_room;

    // Frame walk for the byte in the input register.
    always_comb begin
        cur_pos    = pos_reg;
        cur_slen   = slen_reg;
        cur_beacon = beacon_reg;
        cur_phase  = phase_reg;
        cur_npos   = npos_reg;
        cur_eid    = eid_reg;
        cur_elen   = elen_reg;
        cur_off    = off_reg;
        cur_pw     = pw_reg;
        cur_akm    = akm_reg;
        cur_idx    = idx_reg;
        cur_oui    = oui_reg;
        cur_w2     = w2_reg;
        cur_w3     = w3_reg;
        len_wide   = CW'(len_reg);
        // A frame start samples type and length and clears the walk.
        if (sof_reg) begin
            cur_slen   = (len_wide > CW'(MAX_FRAME_BYTES - 1)) ? POS_MAX : PW'(len_wide);
            cur_beacon = (ptype_reg == PTYPE_MGMT) && (data_reg == FC_BEACON);
            cur_pos    = '0;
            cur_phase  = PH_IDLE;
            cur_npos   = NW'(IE_START);
            cur_eid    = '0;
            cur_elen   = '0;
            cur_off    = '0;
            cur_pw     = '0;
            cur_akm    = '0;
            cur_idx    = '0;
            cur_oui    = '0;
            cur_w2     = 1'b0;
            cur_w3     = 1'b0;
        end

        slen_next   = cur_slen;
        beacon_next = cur_beacon;
        phase_next  = cur_phase;
        npos_next   = cur_npos;
        eid_next    = cur_eid;
        elen_next   = cur_elen;
        off_next    = cur_off;
        pw_next     = cur_pw;
        akm_next    = cur_akm;
        idx_next    = cur_idx;
        oui_next    = cur_oui;
        w2_next     = cur_w2;
        w3_next     = cur_w3;
        pos_next    = (cur_pos < POS_MAX) ? cur_pos + PW'(1) : cur_pos;

        p_ext   = LW'(cur_pos);
        l_ext   = LW'(cur_slen);
        akm_at  = 19'({cur_pw, 2'b00}) + 19'd8;
        o_wide  = 19'(cur_off);
        new_off = cur_off + 8'd1;
        e_bssid = 1'b0;
        e_ssid  = 1'b0;
        e_verd  = 1'b0;
        e_done  = 1'b0;
        verdict = 2'd0;

        if (cur_beacon) begin
            e_bssid = (cur_pos >= PW'(BSSID_FIRST)) && (cur_pos <= PW'(BSSID_LAST))
                   && (p_ext < l_ext);
            // Element walk, only ahead of the FCS.
            if (p_ext + LW'(FCS_BYTES) < l_ext) begin
                priority if (cur_phase == PH_IDLE && NW'(cur_pos) == cur_npos) begin
                    if (p_ext + LW'(FCS_BYTES + 2) < l_ext) begin
                        eid_next   = data_reg;
                        phase_next = PH_LEN;
                    end else begin
                        phase_next = PH_STOP;
                    end
                end else if (cur_phase == PH_LEN) begin
                    elen_next = data_reg;
                    off_next  = '0;
                    pw_next   = '0;
                    akm_next  = '0;
                    idx_next  = '0;
                    oui_next  = '0;
                    w2_next   = 1'b0;
                    w3_next   = 1'b0;
                    npos_next = NW'(cur_pos) + NW'(1) + NW'(data_reg);
                    if (data_reg == 8'd0) begin
                        e_verd     = (cur_eid == EID_RSN);
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end else if (cur_phase == PH_BODY) begin
                    e_ssid = (cur_eid == EID_SSID);
                    // RSN body: pairwise count, pairwise suites, AKM count, AKM suites.
                    if (cur_eid == EID_RSN) begin
                        priority if (cur_off == 8'd6) begin
                            pw_next = {8'h00, data_reg};
                        end else if (cur_off == 8'd7) begin
                            pw_next = {data_reg, cur_pw[7:0]};
                        end else if (cur_off >= 8'd8) begin
                            priority if (o_wide == akm_at) begin
                                akm_next = {8'h00, data_reg};
                            end else if (o_wide == akm_at + 19'd1) begin
                                akm_next = {data_reg, cur_akm[7:0]};
                            end else if (o_wide >= akm_at + 19'd2) begin
                                unique case (cur_off[1:0] + 2'd2)
                                    2'd0: oui_next = (data_reg == OUI_B0) ? 2'd1 : 2'd0;
                                    2'd1: oui_next = (cur_oui == 2'd1 && data_reg == OUI_B1)
                                                   ? 2'd2 : 2'd0;
                                    2'd2: oui_next = (cur_oui == 2'd2 && data_reg == OUI_B2)
                                                   ? 2'd3 : 2'd0;
                                    default: begin
                                        if (cur_oui == 2'd3 && cur_idx < cur_akm) begin
                                            if (data_reg == AKM_PSK || data_reg == AKM_FT_PSK
                                                || data_reg == AKM_SAE_LEG) begin
                                                w2_next = 1'b1;
                                            end
                                            if (data_reg == AKM_SAE) begin
                                                w3_next = 1'b1;
                                            end
                                        end
                                        idx_next = cur_idx + 16'd1;
                                        oui_next = 2'd0;
                                    end
                                endcase
                            end else begin
                                akm_next = cur_akm;
                            end
                        end else begin
                            pw_next = cur_pw;
                        end
                    end
                    off_next = new_off;
                    if (new_off >= cur_elen) begin
                        e_verd     = (cur_eid == EID_RSN);
                        phase_next = PH_IDLE;
                    end else if (p_ext + LW'(FCS_BYTES + 1) == l_ext) begin
                        e_verd     = (cur_eid == EID_RSN);
                        phase_next = PH_STOP;
                    end
                    verdict = {w3_next, w2_next};
                end else begin
                    phase_next = cur_phase;
                end
            end
            e_done = (cur_slen != '0) && (p_ext + LW'(1) == l_ext);
        end
    end

    // Pack the results in order: BSSID, SSID, verdict, done.
    always_comb begin
        n  = 2'd0;
        r0 = '0;
        r1 = '0;
        ev = '0;
        if (e_bssid) begin
            ev = '{kind: KIND_BSSID, data: data_reg, security: 2'd0, last: 1'b0};
            if (n == 2'd0) r0 = ev; else r1 = ev;
            n = n + 2'd1;
        end
        if (e_ssid) begin
            ev = '{kind: KIND_SSID, data: data_reg, security: 2'd0, last: 1'b0};
            if (n == 2'd0) r0 = ev; else r1 = ev;
            n = n + 2'd1;
        end
        if (e_verd) begin
            ev = '{kind: KIND_VERDICT, data: 8'd0, security: verdict, last: 1'b0};
            if (n == 2'd0) r0 = ev; else r1 = ev;
            n = n + 2'd1;
        end
        if (e_done) begin
            ev = '{kind: KIND_DONE, data: 8'd0, security: 2'd0, last: 1'b0};
            if (n == 2'd0) r0 = ev; else r1 = ev;
            n = n + 2'd1;
        end
        if (n == 2'd2) begin
            r1.last = 1'b1;
        end else begin
            r0.last = 1'b1;
        end
        push.count = advance ? n : 2'd0;
        push.r0    = r0;
        push.r1    = r1;
    end

    // Input register and walker state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iv_reg     <= 1'b0;
            pos_reg    <= '0;
            slen_reg   <= '0;
            beacon_reg <= 1'b0;
            phase_reg  <= PH_IDLE;
            npos_reg   <= NW'(IE_START);
            eid_reg    <= '0;
            elen_reg   <= '0;
            off_reg    <= '0;
            pw_reg     <= '0;
            akm_reg    <= '0;
            idx_reg    <= '0;
            oui_reg    <= '0;
            w2_reg     <= 1'b0;
            w3_reg     <= 1'b0;
        end else begin
            if (in_ready) begin
                iv_reg <= in_valid;
            end
            if (advance) begin
                pos_reg    <= pos_next;
                slen_reg   <= slen_next;
                beacon_reg <= beacon_next;
                phase_reg  <= phase_next;
                npos_reg   <= npos_next;
                eid_reg    <= eid_next;
                elen_reg   <= elen_next;
                off_reg    <= off_next;
                pw_reg     <= pw_next;
                akm_reg    <= akm_next;
                idx_reg    <= idx_next;
                oui_reg    <= oui_next;
                w2_reg     <= w2_next;
                w3_reg     <= w3_next;
            end
        end
    end

    // Input payload needs no reset.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg  <= in_data;
            sof_reg   <= in_sof;
            ptype_reg <= in_ptype;
            len_reg   <= in_len;
        end
    end

endmodule

// File: src/bfep_out_queue.sv
// ============================================================================
// bfep_out_queue
// Four-entry result queue that takes up to two results per cycle.
// ============================================================================
module bfep_out_queue
    import bfep_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_item
);

    result_t          mem [OQ_DEPTH];
    logic [OQ_AW-1:0] wr_reg, rd_reg;
    logic [OQ_CW-1:0] cnt_reg, cnt_next;
    logic             pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign room      = (cnt_reg <= OQ_CW'(OQ_DEPTH - 2));
    assign cnt_next  = cnt_reg + OQ_CW'(push.count) - OQ_CW'(pop);
    assign out_item  = mem[rd_reg];

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + OQ_AW'(push.count);
            rd_reg  <= rd_reg + OQ_AW'(pop);
            cnt_reg <= cnt_next;
        end
    end

    // Storage: first result at the write pointer, second one after it.
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_reg] <= push.r0;
        end
        if (push.count == 2'd2) begin
            mem[wr_reg + OQ_AW'(1)] <= push.r1;
        end
    end

endmodule

// File: src/beacon_frame_element_parser.sv
// ============================================================================
// beacon_frame_element_parser
// Beacon BSSID, SSID and RSN security extraction from a byte stream.
// ============================================================================
// Takes one frame byte per cycle, with packet type and frame length on the
// first byte, and reports the BSSID bytes, each SSID byte, an RSN security
// verdict per RSN element and a done event on the last byte of a beacon.
// A byte is taken every cycle as long as the four-entry result queue holds
// at most two results. A byte waits in the input register until the queue has
// room for its results, and the walk logic then writes them into the queue,
// from which they are offered on the output.
// Only a byte that causes two results, or back-pressure on the result side,
// slows the input, since the queue drains one result per cycle.
module beacon_frame_element_parser
    import bfep_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte [7:0], frame_length [19:8], zero fill
    input  logic [2:0]  s_tuser,   // start_of_frame [0], packet_type [2:1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // event_byte [7:0], security [9:8], zero fill
    output logic [1:0]  m_tuser,   // event_kind [1:0]
    output logic        m_tlast
);

    push_t   push;
    logic    room;
    result_t item;

    bfep_parse_core #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata[7:0]),
        .in_sof    (s_tuser[0]),
        .in_ptype  (s_tuser[2:1]),
        .in_len    (s_tdata[19:8]),
        .queue_room(room),
        .push      (push)
    );

    bfep_out_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_item (item)
    );

    // Result fields onto the stream.
    assign m_tdata = {6'b0, item.security, item.data};
    assign m_tuser = item.kind;
    assign m_tlast = item.last;

endmodule

// File: src/bfep_checker.sv
// ============================================================================
// bfep_checker
// Port-level checks on the parser's result stream.
// ============================================================================
module bfep_checker
    import bfep_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // No result is offered right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // A stalled result request stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request withdrawn under stall");

    // Verdict and done events carry no byte.
    a_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_VERDICT || m_tuser == KIND_DONE)
        |-> m_tdata[7:0] == 8'd0)
        else $error("byte on a verdict or done event");

    // Only a verdict carries a security value.
    a_no_sec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_VERDICT |-> m_tdata[9:8] == 2'd0)
        else $error("security value outside a verdict");

    // A done event always closes the run of its byte.
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_DONE |-> m_tlast && m_tdata[15:10] == 6'd0)
        else $error("done event not last in its run");

endmodule

bind beacon_frame_element_parser bfep_checker u_bfep_checker (.*);

// File: tb/beacon_frame_element_parser_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// beacon_frame_element_parser_tb
// Self-checking testbench for the beacon frame element parser.
// ============================================================================
// Frames are sent one byte per request with random source gaps. The result
// channel stalls at random. Every accepted byte goes through a behavioral
// parser, which queues the events it should cause. Each result from the
// block is then checked field by field against the oldest queued event.
// Directed tests cover stray bytes, header and element parsing, RSN verdicts,
// FCS boundary cuts, non-beacon frames and length corner cases. A stream of
// mostly well-formed random beacons follows.
// ============================================================================
module beacon_frame_element_parser_tb;
    import bfep_pkg::*;

    localparam int MAX_FRAME_BYTES = 4096;
    localparam logic [7:0] RSN_VERSION  = 8'h01;
    localparam logic [7:0] CIPHER_CCMP  = 8'h04;
    localparam logic [7:0] EID_VENDOR   = 8'hDD;
    localparam int RANDOM_BEACON_BYTES  = 1000;

    // Ports of the block.
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;     // data_byte [7:0], frame_length [19:8], zero fill
    logic [2:0]  s_tuser = '0;     // start_of_frame [0], packet_type [2:1]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // event_byte [7:0], security [9:8], zero fill
    logic [1:0]  m_tuser;          // event_kind [1:0]
    logic        m_tlast;

    beacon_frame_element_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 100 MHz clock.
    always #5 aclk = ~aclk;

    // Element walk phases of the behavioral parser.
    typedef enum logic [1:0] {WALK_IDLE, WALK_LEN, WALK_BODY, WALK_STOP} walk_t;

    // Behavioral parser state.
    int          frame_pos   = 0;
    int          frame_len   = 0;
    int          next_ie_pos = IE_START;
    bit          in_beacon   = 1'b0;
    logic [7:0]  ie_offset   = '0;
    logic [7:0]  ie_id       = '0;
    logic [7:0]  ie_len      = '0;
    logic [15:0] pairwise_n  = '0;
    logic [15:0] akm_n       = '0;
    logic [15:0] akm_idx     = '0;
    logic [1:0]  oui_run     = '0;
    bit          wpa2_found  = 1'b0;
    bit          wpa3_found  = 1'b0;
    walk_t       walk        = WALK_IDLE;

    // Events the block still owes, oldest first.
    result_t parsed_events[$];

    // Frame under construction and the AKM suites for the next RSN element.
    logic [7:0]  frame_buf[$];
    logic [31:0] akm_list[$];

    int mismatch_count = 0;
    bit src_steady  = 1'b0;
    bit sink_steady = 1'b0;
    int sink_stall  = 0;

    // Mismatch reporting; printing stops after a hundred lines but counting goes on.
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatch_count < 100)
            $display("%0t: event check failed on %s: got %0h, want %0h",
                     $time, what, got, want);
        mismatch_count++;
    endtask

    // Per-element RSN bookkeeping, cleared at each length byte and frame start.
    function automatic void clear_rsn();
        ie_offset  = '0;
        pairwise_n = '0;
        akm_n      = '0;
        akm_idx    = '0;
        oui_run    = '0;
        wpa2_found = 1'b0;
        wpa3_found = 1'b0;
    endfunction

    // Advance the behavioral parser by one accepted byte and queue its events.
    task automatic parse_frame_byte(input logic [7:0] data_in, input logic sof,
                                    input logic [1:0] ptype, input logic [11:0] flen);
        result_t    evs[$];
        int         p;
        int         boundary;
        int         o;
        int         suite_base;
        logic [1:0] verdict;
        bit         give_verdict;

        verdict = {wpa3_found, wpa2_found};
        give_verdict = 1'b0;

        // Frame start samples type and length and restarts the walk.
        if (sof) begin
            frame_len = (int'(flen) > MAX_FRAME_BYTES - 1) ? MAX_FRAME_BYTES - 1 : int'(flen);
            in_beacon = (ptype == PTYPE_MGMT) && (data_in == FC_BEACON);
            frame_pos = 0;
            ie_id = '0;
            ie_len = '0;
            clear_rsn();
            walk = WALK_IDLE;
            next_ie_pos = IE_START;
        end
        p = frame_pos;
        if (frame_pos < MAX_FRAME_BYTES - 1)
            frame_pos++;

        if (in_beacon) begin
            boundary = frame_len - FCS_BYTES;

            // BSSID bytes inside the frame.
            if (p >= BSSID_FIRST && p <= BSSID_LAST && p < frame_len)
                evs.push_back('{kind: KIND_BSSID, data: data_in, security: 2'd0, last: 1'b0});

            // Element walk, stopped at the FCS boundary.
            if (p < boundary) begin
                if (walk == WALK_IDLE && p == next_ie_pos) begin
                    if (p + 2 < boundary) begin
                        ie_id = data_in;
                        walk = WALK_LEN;
                    end else begin
                        walk = WALK_STOP;
                    end
                end else if (walk == WALK_LEN) begin
                    ie_len = data_in;
                    clear_rsn();
                    next_ie_pos = p + 1 + int'(data_in);
                    if (data_in == 8'd0) begin
                        give_verdict = (ie_id == EID_RSN);
                        verdict = 2'd0;
                        walk = WALK_IDLE;
                    end else begin
                        walk = WALK_BODY;
                    end
                end else if (walk == WALK_BODY) begin
                    if (ie_id == EID_SSID) begin
                        evs.push_back('{kind: KIND_SSID, data: data_in, security: 2'd0,
                                        last: 1'b0});
                    end else if (ie_id == EID_RSN) begin
                        // Pairwise count, pairwise suites, AKM count, AKM suites.
                        o = int'(ie_offset);
                        if (o == 6) begin
                            pairwise_n = {8'd0, data_in};
                        end else if (o == 7) begin
                            pairwise_n[15:8] = data_in;
                        end else if (o >= 8) begin
                            suite_base = 8 + 4 * int'(pairwise_n);
                            if (o == suite_base) begin
                                akm_n = {8'd0, data_in};
                            end else if (o == suite_base + 1) begin
                                akm_n[15:8] = data_in;
                            end else if (o >= suite_base + 2) begin
                                case ((o - suite_base - 2) % 4)
                                    0: oui_run = (data_in == OUI_B0) ? 2'd1 : 2'd0;
                                    1: oui_run = (oui_run == 2'd1 && data_in == OUI_B1) ? 2'd2 : 2'd0;
                                    2: oui_run = (oui_run == 2'd2 && data_in == OUI_B2) ? 2'd3 : 2'd0;
                                    default: begin
                                        if (oui_run == 2'd3 && akm_idx < akm_n) begin
                                            if (data_in == AKM_PSK || data_in == AKM_FT_PSK ||
                                                data_in == AKM_SAE_LEG)
                                                wpa2_found = 1'b1;
                                            if (data_in == AKM_SAE)
                                                wpa3_found = 1'b1;
                                        end
                                        akm_idx = akm_idx + 16'd1;
                                        oui_run = 2'd0;
                                    end
                                endcase
                            end
                        end
                    end
                    ie_offset = ie_offset + 8'd1;
                    if (ie_offset >= ie_len) begin
                        give_verdict = (ie_id == EID_RSN);
                        walk = WALK_IDLE;
                    end else if (p == boundary - 1) begin
                        give_verdict = (ie_id == EID_RSN);
                        walk = WALK_STOP;
                    end
                    verdict = {wpa3_found, wpa2_found};
                end
            end

            if (give_verdict)
                evs.push_back('{kind: KIND_VERDICT, data: 8'd0, security: verdict, last: 1'b0});

            // Done event on the last byte of a non-empty frame.
            if (frame_len > 0 && p == frame_len - 1)
                evs.push_back('{kind: KIND_DONE, data: 8'd0, security: 2'd0, last: 1'b0});
        end

        if (evs.size() > 0)
            evs[evs.size() - 1].last = 1'b1;
        foreach (evs[i])
            parsed_events.push_back(evs[i]);
    endtask

    // Send one byte request after a random gap and wait for it to be taken.
    task automatic send_byte(input logic [7:0] data_in, input logic sof,
                             input logic [1:0] ptype, input logic [11:0] flen);
        int gap;

        if ($urandom_range(0, 49) == 0)
            src_steady = !src_steady;
        gap = src_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, flen, data_in};
        s_tuser  <= {ptype, sof};
        do @(posedge aclk); while (!s_tready);
        parse_frame_byte(data_in, sof, ptype, flen);
    endtask

    // Send the frame buffer, start flag on its first byte.
    task automatic send_frame(input logic [1:0] ptype, input int flen);
        foreach (frame_buf[i])
            send_byte(frame_buf[i], i == 0, ptype, flen[11:0]);
    endtask

    // Frame builders.
    function automatic void start_beacon_header();
        frame_buf = {FC_BEACON};
        repeat (IE_START - 1)
            frame_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_ssid(input int len);
        frame_buf.push_back(EID_SSID);
        frame_buf.push_back(8'(len));
        repeat (len)
            frame_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_other(input logic [7:0] id, input int len);
        frame_buf.push_back(id);
        frame_buf.push_back(8'(len));
        repeat (len)
            frame_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_fcs();
        repeat (FCS_BYTES)
            frame_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    // One AKM suite selector, bytes in wire order from the low end.
    function automatic logic [31:0] akm_suite(input bit oui_ok, input logic [7:0] akm_type);
        logic [31:0] suite;
        suite = {akm_type, OUI_B2, OUI_B1, OUI_B0};
        if (!oui_ok)
            suite[8 * $urandom_range(0, 2) +: 8] ^= 8'($urandom_range(1, 255));
        return suite;
    endfunction

    // RSN element with the given pairwise count field and suites, then akm_list.
    function automatic void add_rsn(input int pair_field, input int n_pair, input int akm_field);
        logic [7:0] body[$];
        body = {RSN_VERSION, 8'h00, OUI_B0, OUI_B1, OUI_B2, CIPHER_CCMP,
                pair_field[7:0], pair_field[15:8]};
        repeat (n_pair)
            body = {body, OUI_B0, OUI_B1, OUI_B2, CIPHER_CCMP};
        body.push_back(akm_field[7:0]);
        body.push_back(akm_field[15:8]);
        foreach (akm_list[i])
            for (int k = 0; k < 4; k++)
                body.push_back(akm_list[i][8 * k +: 8]);
        frame_buf.push_back(EID_RSN);
        frame_buf.push_back(8'(body.size()));
        frame_buf = {frame_buf, body};
    endfunction

    function automatic logic [7:0] pick_akm_type();
        case ($urandom_range(0, 6))
            0: return AKM_PSK;
            1: return AKM_FT_PSK;
            2: return AKM_SAE_LEG;
            3: return AKM_SAE;
            4: return 8'h01;
            5: return 8'h06;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Result checking and random back-pressure.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (parsed_events.size() == 0) begin
                    report_mismatch("result with no event pending", {m_tuser, m_tdata[13:0]},
                                    16'd0);
                end else begin
                    want = parsed_events.pop_front();
                    if (m_tuser !== want.kind)
                        report_mismatch("event_kind", 16'(m_tuser), 16'(want.kind));
                    if (m_tdata[7:0] !== want.data)
                        report_mismatch("event_byte", 16'(m_tdata[7:0]), 16'(want.data));
                    if (m_tdata[9:8] !== want.security)
                        report_mismatch("security", 16'(m_tdata[9:8]), 16'(want.security));
                    if (m_tlast !== want.last)
                        report_mismatch("last_of_run", 16'(m_tlast), 16'(want.last));
                end
                if ($urandom_range(0, 63) == 0)
                    sink_steady = !sink_steady;
                sink_stall = sink_steady ? 0 : $urandom_range(0, 10);
            end else if (sink_stall > 0) begin
                sink_stall--;
            end
            m_tready <= (sink_stall == 0);
        end
    end

    // Bytes before any frame start are ignored.
    task automatic test_stray_bytes();
        send_byte(8'h00, 1'b0, PTYPE_MGMT, 12'd0);
        send_byte(8'hFF, 1'b0, 2'd3, 12'hFFF);
        send_byte(FC_BEACON, 1'b0, PTYPE_MGMT, 12'd64);
    endtask

    // Shortest beacon with a full header: BSSID bytes and the done event.
    task automatic test_minimal_beacon();
        frame_buf = {FC_BEACON};
        for (int i = 1; i < IE_START; i++)
            frame_buf.push_back(i[0] ? 8'hFF : 8'h00);
        add_fcs();
        send_frame(PTYPE_MGMT, frame_buf.size());
    endtask

    // SSID bytes, an empty RSN element and RSN verdict variants.
    task automatic test_ssid_and_rsn();
        start_beacon_header();
        frame_buf = {frame_buf, EID_SSID, 8'd3, 8'h00, 8'hFF, 8'h5A};
        frame_buf = {frame_buf, EID_RSN, 8'd0};
        akm_list = {akm_suite(1'b1, AKM_PSK)};
        add_rsn(1, 1, 1);
        akm_list = {akm_suite(1'b1, AKM_SAE), akm_suite(1'b1, AKM_SAE_LEG)};
        add_rsn(2, 2, 2);
        // The AKM count covers only the first suite, so the SAE suite is not counted.
        akm_list = {akm_suite(1'b1, AKM_FT_PSK), akm_suite(1'b1, AKM_SAE)};
        add_rsn(0, 0, 1);
        // A foreign OUI leaves the verdict unknown.
        akm_list = {akm_suite(1'b0, AKM_PSK)};
        add_rsn(1, 1, 1);
        add_other(EID_VENDOR, 6);
        add_fcs();
        send_frame(PTYPE_MGMT, frame_buf.size());
    endtask

    // Elements cut by the FCS boundary.
    task automatic test_boundary_cut();
        // RSN element cut at body offset 10: verdict comes on the last byte before the FCS.
        start_beacon_header();
        add_ssid(3);
        akm_list = {akm_suite(1'b1, AKM_SAE)};
        add_rsn(1, 1, 1);
        add_fcs();
        send_frame(PTYPE_MGMT, IE_START + 5 + 2 + 10 + FCS_BYTES);

        // Element header too close to the boundary is not read.
        start_beacon_header();
        frame_buf = {frame_buf, EID_SSID, 8'd5};
        add_fcs();
        send_frame(PTYPE_MGMT, IE_START + 2 + FCS_BYTES);

        // SSID element longer than what is left of the frame.
        start_beacon_header();
        add_ssid(10);
        send_frame(PTYPE_MGMT, IE_START + 2 + 3 + FCS_BYTES);
    endtask

    // Non-beacon frames cause no results.
    task automatic test_non_beacon();
        for (int t = 1; t < 4; t++) begin
            start_beacon_header();
            frame_buf = frame_buf[0:23];
            send_frame(2'(t), 24);
        end
        start_beacon_header();
        frame_buf = frame_buf[0:23];
        frame_buf[0] = 8'h40;
        send_frame(PTYPE_MGMT, 24);
    endtask

    // Zero and tiny lengths, bytes past the length and a restart mid-frame.
    task automatic test_length_edges();
        start_beacon_header();
        send_frame(PTYPE_MGMT, 0);

        frame_buf = {FC_BEACON, 8'h11, 8'h22};
        send_frame(PTYPE_MGMT, 1);

        start_beacon_header();
        frame_buf = frame_buf[0:23];
        send_frame(PTYPE_MGMT, 20);

        start_beacon_header();
        frame_buf = frame_buf[0:29];
        send_frame(PTYPE_MGMT, 60);
    endtask

    // Mostly well-formed beacons with random content, plus noise.
    task automatic test_random_traffic();
        int         beacon_bytes;
        int         flen;
        int         n_akm;
        int         n_pair;
        logic [1:0] ptype;
        logic [7:0] fc;

        beacon_bytes = 0;
        while (beacon_bytes < RANDOM_BEACON_BYTES) begin
            case ($urandom_range(0, 99)) inside
                [0:79]: begin
                    start_beacon_header();
                    repeat ($urandom_range(0, 5)) begin
                        case ($urandom_range(0, 9))
                            0, 1, 2: add_ssid($urandom_range(0, 32));
                            3, 4, 5: begin
                                akm_list = {};
                                n_akm = $urandom_range(0, 4);
                                repeat (n_akm)
                                    akm_list.push_back(akm_suite($urandom_range(0, 4) != 0,
                                                                 pick_akm_type()));
                                n_pair = $urandom_range(0, 3);
                                add_rsn(($urandom_range(0, 9) == 0) ?
                                            $urandom_range(0, 65535) : n_pair,
                                        n_pair,
                                        ($urandom_range(0, 3) == 0) ?
                                            $urandom_range(0, 5) : n_akm);
                            end
                            6: add_other(EID_RSN, $urandom_range(0, 12));
                            default: add_other(8'($urandom_range(0, 255)),
                                               $urandom_range(0, 24));
                        endcase
                    end
                    if ($urandom_range(0, 4) == 0)
                        repeat ($urandom_range(1, 3))
                            frame_buf.push_back(8'($urandom_range(0, 255)));
                    add_fcs();
                    flen = frame_buf.size();
                    case ($urandom_range(0, 9))
                        0: flen = $urandom_range(0, frame_buf.size());
                        1: flen = frame_buf.size() + $urandom_range(1, 8);
                        default: ;
                    endcase
                    send_frame(PTYPE_MGMT, flen);
                    beacon_bytes += frame_buf.size();
                end
                [80:91]: begin
                    // Wrong type or wrong frame control byte.
                    ptype = 2'($urandom_range(0, 3));
                    fc = 8'($urandom_range(0, 255));
                    if (ptype == PTYPE_MGMT && fc == FC_BEACON)
                        fc = 8'h40;
                    else if (ptype != PTYPE_MGMT && $urandom_range(0, 1) == 1)
                        fc = FC_BEACON;
                    frame_buf = {fc};
                    repeat ($urandom_range(0, 39))
                        frame_buf.push_back(8'($urandom_range(0, 255)));
                    send_frame(ptype, $urandom_range(0, 4095));
                end
                default: begin
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom_range(0, 255)), 1'b0, 2'($urandom_range(0, 3)),
                                  12'($urandom_range(0, 4095)));
                end
            endcase
        end
    endtask

    // Test sequence.
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_stray_bytes();
        test_minimal_beacon();
        test_ssid_and_rsn();
        test_boundary_cut();
        test_non_beacon();
        test_length_edges();
        test_random_traffic();
        s_tvalid <= 1'b0;

        // Drain the remaining events, then wait for anything extra.
        for (int i = 0; i < 20000 && parsed_events.size() > 0; i++)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (parsed_events.size() > 0)
            report_mismatch("events never produced", 16'(parsed_events.size()), 16'd0);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
